### rtl/core/gof_pkg.sv
// Shared widths, constants and transaction types of the Gaussian outlier filter.
package gof_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ADDR_W     = IDX_W + 1;
   localparam int INDEX_W    = 6;
   localparam int SUM_W      = COORD_BITS + CNT_W;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SSQ_W      = SQ_W + IDX_W;
   localparam int VAR_W      = SQ_W;
   localparam int NUM_W      = SQ_W + 8;
   localparam int DEN_W      = VAR_W + 1;
   localparam int DIV_CNT_W  = $clog2(NUM_W);
   localparam int P_W        = $clog2(VAR_W);
   localparam int LOG_W      = P_W + 8;
   localparam int HL_W       = LOG_W + 2;
   localparam int LN2_W      = 17;
   localparam int PROD_W     = HL_W + LN2_W;
   localparam int HL_SHIFT   = 17;
   localparam int SCORE_W    = NUM_W + 2;
   localparam int THR_W      = 16;
   localparam int RAM_DEPTH  = 2 * MAX_POINTS;
   localparam int RAM_W      = 2 * COORD_BITS;

   localparam logic [LN2_W-1:0]  LN2_Q16   = LN2_W'(45426);
   localparam logic [8:0]        LN2PI_Q8  = 9'd470;
   localparam logic [HL_W-1:0]   LOG_BIAS  = HL_W'(4096);
   localparam logic [THR_W-1:0]  THR_RESET = 16'd2048;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         final_point;
   } req_type;

   typedef struct packed {
      logic               keep;
      logic [INDEX_W-1:0] point_index;
      logic               final_result;
   } rsp_type;

   typedef struct packed {
      logic                    bank;
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum_x;
      logic signed [SUM_W-1:0] sum_y;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [RAM_W-1:0]  data;
   } ram_wr_type;

   typedef struct packed {
      logic busy;
      logic job_pop;
   } back_status_type;

endpackage

### rtl/core/gof_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gof_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gof_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module gof_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [gof_pkg::NUM_W-1:0] dividend,
   input  logic [gof_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [gof_pkg::NUM_W-1:0] quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [gof_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [gof_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [gof_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [gof_pkg::NUM_W-1:0]     quo_ff, quo_in;
   logic [gof_pkg::DEN_W:0]       shifted;
   logic [gof_pkg::DEN_W:0]       diff;
   logic                          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[gof_pkg::NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[gof_pkg::DEN_W-1:0] : shifted[gof_pkg::DEN_W-1:0];
         quo_in = {quo_ff[gof_pkg::NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == gof_pkg::DIV_CNT_W'(gof_pkg::NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/gof_queue.sv
// Two-entry job queue between the point collector and the evaluator.
module gof_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gof_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output gof_pkg::job_type head_job
);

   gof_pkg::job_type entry_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_job   = entry_ff[rd_ff];

endmodule

### rtl/core/gof_front.sv
// Point collector: stores points in the open bank and sums them per axis.
module gof_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  gof_pkg::req_type    req_payload,
   output logic                req_stall,
   input  logic                queue_full,
   output gof_pkg::ram_wr_type ram_wr,
   output logic                job_push,
   output gof_pkg::job_type    job
);

   logic                             bank_ff, bank_in;
   logic [gof_pkg::CNT_W-1:0]        count_ff, count_in;
   logic signed [gof_pkg::SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [gof_pkg::SUM_W-1:0] sum_y_ff, sum_y_in;
   logic                             accept;
   logic                             room;
   logic [gof_pkg::CNT_W-1:0]        count_new;
   logic signed [gof_pkg::SUM_W-1:0] sum_x_new;
   logic signed [gof_pkg::SUM_W-1:0] sum_y_new;

   always_comb begin
      accept    = req_valid && !queue_full;
      room      = count_ff < gof_pkg::CNT_W'(gof_pkg::MAX_POINTS);
      count_new = count_ff;
      sum_x_new = sum_x_ff;
      sum_y_new = sum_y_ff;
      if (room) begin
         count_new = count_ff + 1'b1;
         sum_x_new = sum_x_ff + gof_pkg::SUM_W'(req_payload.point_x);
         sum_y_new = sum_y_ff + gof_pkg::SUM_W'(req_payload.point_y);
      end
      ram_wr.en   = accept && room;
      ram_wr.addr = {bank_ff, count_ff[gof_pkg::IDX_W-1:0]};
      ram_wr.data = {req_payload.point_x, req_payload.point_y};
      job_push    = accept && req_payload.final_point;
      job.bank    = bank_ff;
      job.count   = count_new;
      job.sum_x   = sum_x_new;
      job.sum_y   = sum_y_new;
      bank_in     = bank_ff;
      count_in    = count_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      if (accept) begin
         if (req_payload.final_point) begin
            // hand the set over and open the other bank
            bank_in  = ~bank_ff;
            count_in = '0;
            sum_x_in = '0;
            sum_y_in = '0;
         end else begin
            count_in = count_new;
            sum_x_in = sum_x_new;
            sum_y_in = sum_y_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   assign req_stall = queue_full;

endmodule

### rtl/core/gof_back.sv
// Evaluator: statistics of one set, then one keep decision per point.
module gof_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  gof_pkg::job_type              job,
   input  logic [gof_pkg::THR_W-1:0]     log_threshold,
   output logic [gof_pkg::ADDR_W-1:0]    ram_rd_addr,
   input  logic [gof_pkg::RAM_W-1:0]     ram_rd_data,
   output gof_pkg::back_status_type      status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gof_pkg::rsp_type              rsp_payload
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MX   = 5'd1;
   localparam logic [4:0] S_MY   = 5'd2;
   localparam logic [4:0] S_VRD  = 5'd3;
   localparam logic [4:0] S_VWT  = 5'd4;
   localparam logic [4:0] S_VSQ  = 5'd5;
   localparam logic [4:0] S_VACC = 5'd6;
   localparam logic [4:0] S_VX   = 5'd7;
   localparam logic [4:0] S_VY   = 5'd8;
   localparam logic [4:0] S_LX   = 5'd9;
   localparam logic [4:0] S_LY   = 5'd10;
   localparam logic [4:0] S_HL   = 5'd11;
   localparam logic [4:0] S_HL2  = 5'd12;
   localparam logic [4:0] S_ERD  = 5'd13;
   localparam logic [4:0] S_EWT  = 5'd14;
   localparam logic [4:0] S_ESQ  = 5'd15;
   localparam logic [4:0] S_EDX  = 5'd16;
   localparam logic [4:0] S_EDY  = 5'd17;
   localparam logic [4:0] S_EOUT = 5'd18;

   localparam int CW = gof_pkg::COORD_BITS;

   logic [4:0]                          state_ff, state_in;
   logic [gof_pkg::CNT_W-1:0]           i_ff, i_in;
   logic signed [CW-1:0]                mean_x_ff, mean_x_in;
   logic signed [CW-1:0]                mean_y_ff, mean_y_in;
   logic [CW-1:0]                       mag_x_ff, mag_x_in;
   logic [CW-1:0]                       mag_y_ff, mag_y_in;
   logic [gof_pkg::SQ_W-1:0]            sq_x_ff, sq_x_in;
   logic [gof_pkg::SQ_W-1:0]            sq_y_ff, sq_y_in;
   logic [gof_pkg::SSQ_W-1:0]           ssq_x_ff, ssq_x_in;
   logic [gof_pkg::SSQ_W-1:0]           ssq_y_ff, ssq_y_in;
   logic [gof_pkg::VAR_W-1:0]           var_x_ff, var_x_in;
   logic [gof_pkg::VAR_W-1:0]           var_y_ff, var_y_in;
   logic                                degen_ff, degen_in;
   logic [gof_pkg::VAR_W-1:0]           norm_ff, norm_in;
   logic [gof_pkg::P_W-1:0]             shift_ff, shift_in;
   logic [gof_pkg::LOG_W-1:0]           log_x_ff, log_x_in;
   logic [gof_pkg::LOG_W-1:0]           log_y_ff, log_y_in;
   logic signed [gof_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [gof_pkg::HL_W-1:0]     hl_ff, hl_in;
   logic [gof_pkg::NUM_W-1:0]           qx_ff, qx_in;
   logic                                keep_ff, keep_in;
   logic                                div_start_ff, div_start_in;
   logic [gof_pkg::NUM_W-1:0]           div_a_ff, div_a_in;
   logic [gof_pkg::DEN_W-1:0]           div_b_ff, div_b_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   gof_pkg::rsp_type                    rsp_ff, rsp_in;

   logic                                div_done;
   logic [gof_pkg::NUM_W-1:0]           div_q;

   logic [gof_pkg::SUM_W-1:0]           sum_mag_x, sum_mag_y;
   logic [CW-1:0]                       q_lo;
   logic signed [CW-1:0]                pt_x, pt_y;
   logic signed [CW:0]                  d_x, d_y;
   logic [gof_pkg::SSQ_W-1:0]           ssq_x_new, ssq_y_new;
   logic signed [gof_pkg::HL_W-1:0]     log_t;
   logic signed [gof_pkg::PROD_W-1:0]   prod_adj;
   logic signed [gof_pkg::SCORE_W-1:0]  score;
   logic signed [gof_pkg::SCORE_W-1:0]  thr_s;
   logic                                last_pt;
   logic                                slot_free;

   gof_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      sum_mag_x = job.sum_x[gof_pkg::SUM_W-1] ? -job.sum_x : job.sum_x;
      sum_mag_y = job.sum_y[gof_pkg::SUM_W-1] ? -job.sum_y : job.sum_y;
      q_lo      = div_q[CW-1:0];
      pt_x      = ram_rd_data[gof_pkg::RAM_W-1 -: CW];
      pt_y      = ram_rd_data[CW-1:0];
      d_x       = (CW+1)'(pt_x) - (CW+1)'(mean_x_ff);
      d_y       = (CW+1)'(pt_y) - (CW+1)'(mean_y_ff);
      ssq_x_new = ssq_x_ff + gof_pkg::SSQ_W'(sq_x_ff);
      ssq_y_new = ssq_y_ff + gof_pkg::SSQ_W'(sq_y_ff);
      log_t     = $signed(gof_pkg::HL_W'(log_x_ff)) + $signed(gof_pkg::HL_W'(log_y_ff))
                - $signed(gof_pkg::LOG_BIAS);
      prod_adj  = prod_ff[gof_pkg::PROD_W-1]
                ? prod_ff + $signed(gof_pkg::PROD_W'((1 << gof_pkg::HL_SHIFT) - 1))
                : prod_ff;
      score     = $signed({2'b00, qx_ff}) + $signed({2'b00, div_q})
                + $signed(gof_pkg::SCORE_W'(gof_pkg::LN2PI_Q8))
                + gof_pkg::SCORE_W'(hl_ff);
      thr_s     = $signed(gof_pkg::SCORE_W'(log_threshold));
      last_pt   = i_ff == job.count - 1'b1;
      slot_free = !rsp_valid_ff || !rsp_stall;

      state_in     = state_ff;
      i_in         = i_ff;
      mean_x_in    = mean_x_ff;
      mean_y_in    = mean_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      sq_x_in      = sq_x_ff;
      sq_y_in      = sq_y_ff;
      ssq_x_in     = ssq_x_ff;
      ssq_y_in     = ssq_y_ff;
      var_x_in     = var_x_ff;
      var_y_in     = var_y_ff;
      degen_in     = degen_ff;
      norm_in      = norm_ff;
      shift_in     = shift_ff;
      log_x_in     = log_x_ff;
      log_y_in     = log_y_ff;
      prod_in      = prod_ff;
      hl_in        = hl_ff;
      qx_in        = qx_ff;
      keep_in      = keep_ff;
      div_start_in = 1'b0;
      div_a_in     = div_a_ff;
      div_b_in     = div_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      status.busy    = state_ff != S_IDLE;
      status.job_pop = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               div_a_in     = gof_pkg::NUM_W'(sum_mag_x);
               div_b_in     = gof_pkg::DEN_W'(job.count);
               div_start_in = 1'b1;
               state_in     = S_MX;
            end
         end
         S_MX: begin
            if (div_done) begin
               mean_x_in    = job.sum_x[gof_pkg::SUM_W-1] ? -q_lo : q_lo;
               div_a_in     = gof_pkg::NUM_W'(sum_mag_y);
               div_start_in = 1'b1;
               state_in     = S_MY;
            end
         end
         S_MY: begin
            if (div_done) begin
               mean_y_in = job.sum_y[gof_pkg::SUM_W-1] ? -q_lo : q_lo;
               i_in      = '0;
               ssq_x_in  = '0;
               ssq_y_in  = '0;
               state_in  = S_VRD;
            end
         end
         S_VRD: state_in = S_VWT;
         S_VWT: begin
            mag_x_in = d_x[CW] ? CW'(-d_x) : CW'(d_x);
            mag_y_in = d_y[CW] ? CW'(-d_y) : CW'(d_y);
            state_in = S_VSQ;
         end
         S_VSQ: begin
            sq_x_in  = gof_pkg::SQ_W'(mag_x_ff) * gof_pkg::SQ_W'(mag_x_ff);
            sq_y_in  = gof_pkg::SQ_W'(mag_y_ff) * gof_pkg::SQ_W'(mag_y_ff);
            state_in = S_VACC;
         end
         S_VACC: begin
            ssq_x_in = ssq_x_new;
            ssq_y_in = ssq_y_new;
            if (last_pt) begin
               div_a_in     = gof_pkg::NUM_W'(ssq_x_new);
               div_start_in = 1'b1;
               state_in     = S_VX;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_VRD;
            end
         end
         S_VX: begin
            if (div_done) begin
               var_x_in     = div_q[gof_pkg::VAR_W-1:0];
               div_a_in     = gof_pkg::NUM_W'(ssq_y_ff);
               div_start_in = 1'b1;
               state_in     = S_VY;
            end
         end
         S_VY: begin
            if (div_done) begin
               var_y_in = div_q[gof_pkg::VAR_W-1:0];
               degen_in = (var_x_ff == '0) || (div_q[gof_pkg::VAR_W-1:0] == '0);
               norm_in  = var_x_ff;
               shift_in = '0;
               i_in     = '0;
               state_in = ((var_x_ff == '0) || (div_q[gof_pkg::VAR_W-1:0] == '0))
                        ? S_ERD : S_LX;
            end
         end
         S_LX: begin
            if (norm_ff[gof_pkg::VAR_W-1]) begin
               log_x_in = {gof_pkg::P_W'(gof_pkg::VAR_W - 1) - shift_ff,
                           norm_ff[gof_pkg::VAR_W-2 -: 8]};
               norm_in  = var_y_ff;
               shift_in = '0;
               state_in = S_LY;
            end else begin
               norm_in  = norm_ff << 1;
               shift_in = shift_ff + 1'b1;
            end
         end
         S_LY: begin
            if (norm_ff[gof_pkg::VAR_W-1]) begin
               log_y_in = {gof_pkg::P_W'(gof_pkg::VAR_W - 1) - shift_ff,
                           norm_ff[gof_pkg::VAR_W-2 -: 8]};
               state_in = S_HL;
            end else begin
               norm_in  = norm_ff << 1;
               shift_in = shift_ff + 1'b1;
            end
         end
         S_HL: begin
            prod_in  = gof_pkg::PROD_W'(log_t)
                     * $signed(gof_pkg::PROD_W'(gof_pkg::LN2_Q16));
            state_in = S_HL2;
         end
         S_HL2: begin
            hl_in    = gof_pkg::HL_W'(prod_adj >>> gof_pkg::HL_SHIFT);
            state_in = S_ERD;
         end
         S_ERD: begin
            if (degen_ff) begin
               keep_in  = 1'b1;
               state_in = S_EOUT;
            end else begin
               state_in = S_EWT;
            end
         end
         S_EWT: begin
            mag_x_in = d_x[CW] ? CW'(-d_x) : CW'(d_x);
            mag_y_in = d_y[CW] ? CW'(-d_y) : CW'(d_y);
            state_in = S_ESQ;
         end
         S_ESQ: begin
            sq_x_in  = gof_pkg::SQ_W'(mag_x_ff) * gof_pkg::SQ_W'(mag_x_ff);
            sq_y_in  = gof_pkg::SQ_W'(mag_y_ff) * gof_pkg::SQ_W'(mag_y_ff);
            state_in = S_EDX;
            // kick the x distance once the squares land
            div_a_in     = {gof_pkg::SQ_W'(mag_x_ff) * gof_pkg::SQ_W'(mag_x_ff), 8'h00};
            div_b_in     = {var_x_ff, 1'b0};
            div_start_in = 1'b1;
         end
         S_EDX: begin
            if (div_done) begin
               qx_in        = div_q;
               div_a_in     = {sq_y_ff, 8'h00};
               div_b_in     = {var_y_ff, 1'b0};
               div_start_in = 1'b1;
               state_in     = S_EDY;
            end
         end
         S_EDY: begin
            if (div_done) begin
               keep_in  = !(score > thr_s);
               state_in = S_EOUT;
            end
         end
         S_EOUT: begin
            if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.keep         = keep_ff;
               rsp_in.point_index  = gof_pkg::INDEX_W'(i_ff);
               rsp_in.final_result = last_pt;
               if (last_pt) begin
                  status.job_pop = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         div_start_ff <= div_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_x_ff <= mean_x_in;
      mean_y_ff <= mean_y_in;
      mag_x_ff  <= mag_x_in;
      mag_y_ff  <= mag_y_in;
      sq_x_ff   <= sq_x_in;
      sq_y_ff   <= sq_y_in;
      ssq_x_ff  <= ssq_x_in;
      ssq_y_ff  <= ssq_y_in;
      var_x_ff  <= var_x_in;
      var_y_ff  <= var_y_in;
      degen_ff  <= degen_in;
      norm_ff   <= norm_in;
      shift_ff  <= shift_in;
      log_x_ff  <= log_x_in;
      log_y_ff  <= log_y_in;
      prod_ff   <= prod_in;
      hl_ff     <= hl_in;
      qx_ff     <= qx_in;
      keep_ff   <= keep_in;
      div_a_ff  <= div_a_in;
      div_b_ff  <= div_b_in;
      rsp_ff    <= rsp_in;
   end

   assign ram_rd_addr = {job.bank, i_ff[gof_pkg::IDX_W-1:0]};
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/gaussian_outlier_filter.sv
// Top level of the Gaussian outlier filter: collector, job queue, point RAM, evaluator.
//
// Usage: send points as req transactions (req_valid/req_stall/req_payload), one per
// cycle while req_stall is low. A point with final_point set closes the set. Up to
// MAX_POINTS points of a set are stored; later ones are dropped. For each closed set
// the block returns one rsp transaction per stored point, in arrival order, with
// keep, point_index and final_result on the last one.
// Two RAM banks hold two sets, so the next set loads while the previous one is
// evaluated; req_stall rises only when both banks hold closed sets.
// After the closing point the evaluator finds the means and variances (four divisions
// on the shared divider, each point read, squared and summed in turn), then the two
// logarithms and the half log determinant, then two divisions per result, or none
// when a variance is zero. Except in that case, the divider sets the rate.
// A stalled receiver holds the result register and pauses the evaluator; loading
// of the other bank goes on. Reset (synchronous, active high) empties the queue,
// idles both sides and sets log_threshold to 2048; write log_threshold through
// csr_write_enable/csr_write_data only while the block is idle.
module gaussian_outlier_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gof_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gof_pkg::rsp_type              rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [gof_pkg::THR_W-1:0]     csr_write_data
);

   logic [gof_pkg::THR_W-1:0]  log_threshold_ff, log_threshold_in;
   gof_pkg::ram_wr_type        ram_wr;
   logic [gof_pkg::ADDR_W-1:0] ram_rd_addr;
   logic [gof_pkg::RAM_W-1:0]  ram_rd_data;
   logic                       job_push;
   gof_pkg::job_type           push_job;
   logic                       job_full;
   logic                       job_valid;
   gof_pkg::job_type           head_job;
   gof_pkg::back_status_type   back_status;

   // hold the threshold until software rewrites it
   assign log_threshold_in = csr_write_enable ? csr_write_data : log_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_threshold_ff <= gof_pkg::THR_RESET;
      end else begin
         log_threshold_ff <= log_threshold_in;
      end
   end

   gof_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .queue_full  (job_full),
      .ram_wr      (ram_wr),
      .job_push    (job_push),
      .job         (push_job)
   );

   gof_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (back_status.job_pop),
      .full       (job_full),
      .head_valid (job_valid),
      .head_job   (head_job)
   );

   // bank bit on top: collector and evaluator never touch the same half
   gof_ram #(
      .WIDTH (gof_pkg::RAM_W),
      .DEPTH (gof_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gof_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (head_job),
      .log_threshold (log_threshold_ff),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .status        (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload)
   );

   // a closed set must always find a free queue slot
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      !(job_push && job_full))
      else $error("job pushed into a full queue");

   // the evaluator only works on a queued set
   a_busy_has_job: assert property (@(posedge clock) disable iff (reset)
      back_status.busy |-> job_valid)
      else $error("evaluator busy without a queued set");

   // the queue is released as the last result of a set is registered
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      back_status.job_pop |=> (rsp_valid && rsp_payload.final_result))
      else $error("set released without its final result");

endmodule
